// ----- rtl/sfla_pkg.sv -----
`timescale 1ns / 1ps

package sfla_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_LINK
  } state_t;

  // result status codes
  typedef enum logic [2:0] {
    STAT_LIST      = 3'd0,
    STAT_CARVED    = 3'd1,
    STAT_OOM       = 3'd2,
    STAT_TOO_LARGE = 3'd3,
    STAT_FREED     = 3'd4,
    STAT_ZERO      = 3'd5
  } status_t;

  // head table strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_valid;
  } head_ctl_t;

  // link store strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } link_ctl_t;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned SIZE_W = 12;
  localparam int unsigned RSZ_W  = 13;
  localparam int unsigned USED_W = 17;

endpackage

// ----- rtl/sfla_heads.sv -----
`timescale 1ns / 1ps

module sfla_heads #(
  parameter int unsigned CLASS_COUNT = 64,
  parameter int unsigned CLS_W       = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sfla_pkg::head_ctl_t      ctl,
  input  logic [CLS_W-1:0]         rd_cls,
  input  logic [CLS_W-1:0]         wr_cls,
  input  logic [sfla_pkg::ADDR_W-1:0] wr_addr,
  output logic [sfla_pkg::ADDR_W-1:0] rd_addr,
  output logic                     rd_valid
);
  import sfla_pkg::*;

  logic [ADDR_W-1:0]      head_mem [CLASS_COUNT];
  logic [CLASS_COUNT-1:0] valid_r;
  logic [ADDR_W-1:0]      rd_addr_r;
  logic                   rd_valid_r;

  // head address store, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      head_mem[wr_cls] <= wr_addr;
    end
    if (ctl.rd_en) begin
      rd_addr_r <= head_mem[rd_cls];
    end
  end

  // per-class non-empty flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[wr_cls] <= ctl.wr_valid;
      end
      if (ctl.rd_en) begin
        rd_valid_r <= valid_r[rd_cls];
      end
    end
  end

  assign rd_addr  = rd_addr_r;
  assign rd_valid = rd_valid_r;

endmodule

// ----- rtl/sfla_links.sv -----
`timescale 1ns / 1ps

module sfla_links #(
  parameter int unsigned LINK_DEPTH = 16384,
  parameter int unsigned LINK_W     = 14
) (
  input  logic                        clk,
  input  sfla_pkg::link_ctl_t         ctl,
  input  logic [LINK_W-1:0]           rd_idx,
  input  logic [LINK_W-1:0]           wr_idx,
  input  logic [sfla_pkg::ADDR_W-1:0] wr_data,
  output logic [sfla_pkg::ADDR_W-1:0] rd_data
);
  import sfla_pkg::*;

  logic [ADDR_W-1:0] link_mem [LINK_DEPTH];
  logic [ADDR_W-1:0] rd_data_r;

  // one link word per pool word, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      link_mem[wr_idx] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= link_mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/segregated_free_list_allocator_top.sv -----
`timescale 1ns / 1ps

// channel   ports                                              handshake
// request   in_func, in_size_bytes, in_block_address          start && !busy
// result    out_address, out_status, out_bytes_in_use          out_valid, one cycle
//
// A result is registered from ST_HEAD, the state entered when the request is
// taken, and is shown for one cycle; an allocation popped from a free list
// passes through ST_HEAD and then ST_LINK, since the class head and then the
// link word it names are read in turn from synchronous memories.
// busy is high from the taking edge until the result is registered, so a new
// request may be issued in the cycle the previous result is shown.
// rst_n is synchronous: all free lists empty, pool unused, count zero; the link
// store is not cleared. The result side has no stall.
// Pool size (POOL_BYTES) and WORD_BYTES are taken to be powers of two.
module segregated_free_list_allocator_top #(
  parameter int unsigned POOL_BYTES        = 65536,
  parameter int unsigned CHUNK_BYTES       = 1024,
  parameter int unsigned SMALL_LIMIT_BYTES = 256,
  parameter int unsigned WORD_BYTES        = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_func,
  input  logic [sfla_pkg::SIZE_W-1:0]  in_size_bytes,
  input  logic [sfla_pkg::ADDR_W-1:0]  in_block_address,
  output logic                         out_valid,
  output logic [sfla_pkg::ADDR_W-1:0]  out_address,
  output logic [2:0]                   out_status,
  output logic [sfla_pkg::USED_W-1:0]  out_bytes_in_use
);
  import sfla_pkg::*;

  localparam int unsigned CLASS_COUNT = SMALL_LIMIT_BYTES / WORD_BYTES;
  localparam int unsigned CLS_W       = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int unsigned LINK_DEPTH  = POOL_BYTES / WORD_BYTES;
  localparam int unsigned LINK_W      = $clog2(LINK_DEPTH);
  localparam int unsigned WORD_SHIFT  = $clog2(WORD_BYTES);
  localparam int unsigned AW          = $clog2(POOL_BYTES + 1);
  localparam int unsigned RM_W        = $clog2(CHUNK_BYTES + 1);
  localparam int unsigned LAST_BASE   = POOL_BYTES - CHUNK_BYTES;

  state_t            state_r, state_nxt;
  logic              func_r;
  logic [RSZ_W-1:0]  sz_r;
  logic              zero_r, big_r;
  logic [CLS_W-1:0]  cls_r;
  logic [ADDR_W-1:0] blk_r;

  logic [AW-1:0]     carve_r, carve_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [RM_W-1:0]   room_r, room_nxt;
  logic [USED_W-1:0] used_r, used_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_address_r, out_address_nxt;
  status_t           out_status_r, out_status_nxt;

  logic              accept;
  logic [RSZ_W-1:0]  sz_in;
  logic [CLS_W-1:0]  rd_cls;

  head_ctl_t         head_ctl;
  logic [ADDR_W-1:0] head_wr_addr;
  logic [ADDR_W-1:0] head_rd_addr;
  logic              head_rd_valid;

  link_ctl_t         link_ctl;
  logic [LINK_W-1:0] link_rd_idx, link_wr_idx;
  logic [ADDR_W-1:0] link_wr_data, link_rd_data;

  logic              need_chunk, oom;
  logic [AW-1:0]     take_addr;
  logic [RM_W-1:0]   room_base;
  logic [USED_W:0]   used_sum;
  logic [USED_W-1:0] used_add, used_sub;

  // request decode: word rounding and class select
  assign accept = start && !busy;
  assign sz_in  = (RSZ_W'(in_size_bytes) + RSZ_W'(WORD_BYTES - 1)) & ~RSZ_W'(WORD_BYTES - 1);
  assign rd_cls = CLS_W'(sz_in >> WORD_SHIFT);

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      sz_r   <= sz_in;
      zero_r <= (sz_in == '0);
      big_r  <= (sz_in >= RSZ_W'(SMALL_LIMIT_BYTES));
      cls_r  <= rd_cls;
      blk_r  <= in_block_address & ~ADDR_W'(WORD_BYTES - 1);
    end
  end

  // bump pointer: switch to the next chunk when the current one is short
  assign need_chunk = (32'(room_r) < 32'(sz_r));
  assign oom        = need_chunk && (base_r > AW'(LAST_BASE));
  assign take_addr  = need_chunk ? base_r : carve_r;
  assign room_base  = need_chunk ? RM_W'(CHUNK_BYTES) : room_r;

  // saturating byte count
  assign used_sum = {1'b0, used_r} + (USED_W + 1)'(sz_r);
  assign used_add = used_sum[USED_W] ? '1 : used_sum[USED_W-1:0];
  assign used_sub = (used_r >= USED_W'(sz_r)) ? (used_r - USED_W'(sz_r)) : '0;

  // link store addressing
  assign link_rd_idx  = LINK_W'(head_rd_addr >> WORD_SHIFT);
  assign link_wr_idx  = LINK_W'(blk_r >> WORD_SHIFT);
  assign link_wr_data = head_rd_valid ? (head_rd_addr | ADDR_W'(1)) : '0;

  // sequencer: next state, memory strobes and result
  always_comb begin
    state_nxt       = state_r;
    carve_nxt       = carve_r;
    base_nxt        = base_r;
    room_nxt        = room_r;
    used_nxt        = used_r;
    out_valid_nxt   = 1'b0;
    out_address_nxt = '0;
    out_status_nxt  = out_status_r;
    head_ctl        = '0;
    head_wr_addr    = blk_r;
    link_ctl        = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          head_ctl.rd_en = 1'b1;
          state_nxt      = ST_HEAD;
        end
      end
      ST_HEAD: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        if (zero_r) begin
          out_status_nxt = STAT_ZERO;
        end else if (big_r) begin
          out_status_nxt = STAT_TOO_LARGE;
        end else if (func_r) begin
          // push: old head goes into the block's link word
          link_ctl.wr_en    = 1'b1;
          head_ctl.wr_en    = 1'b1;
          head_ctl.wr_valid = 1'b1;
          head_wr_addr      = blk_r;
          used_nxt          = used_sub;
          out_status_nxt    = STAT_FREED;
        end else if (head_rd_valid) begin
          // pop needs the link word first
          link_ctl.rd_en = 1'b1;
          out_valid_nxt  = 1'b0;
          state_nxt      = ST_LINK;
        end else if (oom) begin
          out_status_nxt = STAT_OOM;
        end else begin
          if (need_chunk) begin
            base_nxt = base_r + AW'(CHUNK_BYTES);
          end
          carve_nxt       = take_addr + AW'(sz_r);
          room_nxt        = room_base - RM_W'(sz_r);
          used_nxt        = used_add;
          out_address_nxt = ADDR_W'(take_addr);
          out_status_nxt  = STAT_CARVED;
        end
      end
      ST_LINK: begin
        state_nxt         = ST_IDLE;
        head_ctl.wr_en    = 1'b1;
        head_ctl.wr_valid = link_rd_data[0];
        head_wr_addr      = link_rd_data & ~ADDR_W'(1);
        used_nxt          = used_add;
        out_valid_nxt     = 1'b1;
        out_address_nxt   = head_rd_addr;
        out_status_nxt    = STAT_LIST;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and pool state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      carve_r     <= '0;
      base_r      <= '0;
      room_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      carve_r     <= carve_nxt;
      base_r      <= base_nxt;
      room_r      <= room_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    out_address_r <= out_address_nxt;
    out_status_r  <= out_status_nxt;
  end

  sfla_heads #(
    .CLASS_COUNT (CLASS_COUNT),
    .CLS_W       (CLS_W)
  ) u_heads (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (head_ctl),
    .rd_cls   (rd_cls),
    .wr_cls   (cls_r),
    .wr_addr  (head_wr_addr),
    .rd_addr  (head_rd_addr),
    .rd_valid (head_rd_valid)
  );

  sfla_links #(
    .LINK_DEPTH (LINK_DEPTH),
    .LINK_W     (LINK_W)
  ) u_links (
    .clk     (clk),
    .ctl     (link_ctl),
    .rd_idx  (link_rd_idx),
    .wr_idx  (link_wr_idx),
    .wr_data (link_wr_data),
    .rd_data (link_rd_data)
  );

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_address      = out_address_r;
  assign out_status       = out_status_r;
  assign out_bytes_in_use = used_r;

`ifndef SYNTHESIS
  // a taken request always starts with the head read
  a_accept_to_head: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_HEAD))
    else $error("request not followed by head read");

  // a result beat is never directly followed by another
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("back to back result beats");

  // a result is only shown once the sequencer is back at rest
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result shown while busy");

  // the byte count moves only together with a result
  a_used_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != $past(used_r)) |-> out_valid_r)
    else $error("byte count changed without a result");

  // only list pops and carves return an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_LIST) && (out_status_r != STAT_CARVED))
      |-> (out_address_r == '0))
    else $error("address returned with a non-allocating status");
`endif

endmodule
